[design/i2cseq_pkg.sv]
package i2cseq_pkg;

  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 48;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_START = 3'd1,
    PH_ADDR  = 3'd2,
    PH_PREP  = 3'd3,
    PH_SENT  = 3'd4,
    PH_GET   = 3'd5,
    PH_GOT   = 3'd6,
    PH_STOP  = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    OUT_BUSY = 2'd0,
    OUT_OK   = 2'd1,
    OUT_FAIL = 2'd2
  } outcome_e;

  localparam logic [7:0] StStart   = 8'h08;
  localparam logic [7:0] StMtSla   = 8'h18;
  localparam logic [7:0] StMtData  = 8'h28;
  localparam logic [7:0] StMrSla   = 8'h40;
  localparam logic [7:0] StMrData  = 8'h50;
  localparam logic [7:0] StMrNack  = 8'h58;

  typedef struct packed {
    logic       req_type;
    logic [6:0] device_addr;
    logic [7:0] byte_count;
    logic [7:0] write_byte;
    logic       engine_busy;
    logic       stop_pending;
    logic [7:0] bus_status;
    logic [7:0] read_byte;
  } poll_t;

  typedef struct packed {
    logic [1:0] outcome;
    logic       issue_command;
    logic       cmd_start;
    logic       cmd_stop;
    logic       cmd_ack;
    logic       cmd_enable;
    logic       load_data;
    logic [7:0] data_out;
    logic       got_byte;
    logic [7:0] got_data;
    logic [7:0] byte_index;
    logic [7:0] bytes_done;
  } result_t;

endpackage

[design/i2cseq_poll.sv]
module i2cseq_poll
  import i2cseq_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    en_i,
  input  poll_t   item_i,
  output result_t res_o
);

  phase_e     wr_phase_q, wr_phase_d;
  phase_e     rd_phase_q, rd_phase_d;
  logic [7:0] wr_count_q, wr_count_d;
  logic [7:0] rd_count_q, rd_count_d;
  logic [7:0] rd_left;
  logic       rd_last;
  result_t    res;

  assign rd_left = item_i.byte_count - rd_count_q;
  assign rd_last = (rd_left == 8'd1);

  always_comb begin
    res        = '0;
    res.outcome = OUT_BUSY;
    wr_phase_d = wr_phase_q;
    rd_phase_d = rd_phase_q;
    wr_count_d = wr_count_q;
    rd_count_d = rd_count_q;
    if (!item_i.req_type) begin
      unique case (wr_phase_q)
        PH_START: begin
          if (!item_i.engine_busy) begin
            if (item_i.bus_status != StStart) begin
              res.issue_command = 1'b1;
              res.cmd_stop      = 1'b1;
              res.outcome       = OUT_FAIL;
              wr_phase_d        = PH_IDLE;
            end else begin
              res.load_data     = 1'b1;
              res.data_out      = {item_i.device_addr, 1'b0};
              res.issue_command = 1'b1;
              res.cmd_enable    = 1'b1;
              wr_phase_d        = PH_ADDR;
            end
          end
        end
        PH_ADDR, PH_PREP: begin
          if (wr_phase_q == PH_ADDR && !item_i.engine_busy &&
              item_i.bus_status != StMtSla) begin
            res.outcome = OUT_FAIL;
            wr_phase_d  = PH_IDLE;
          end else if (wr_phase_q == PH_PREP || !item_i.engine_busy) begin
            res.load_data     = 1'b1;
            res.data_out      = item_i.write_byte;
            res.byte_index    = wr_count_q;
            res.issue_command = 1'b1;
            res.cmd_enable    = 1'b1;
            wr_phase_d        = PH_SENT;
          end
        end
        PH_SENT: begin
          if (!item_i.engine_busy) begin
            if (item_i.bus_status != StMtData) begin
              res.outcome = OUT_FAIL;
              wr_phase_d  = PH_IDLE;
            end else begin
              wr_count_d = wr_count_q + 8'd1;
              if (wr_count_d == item_i.byte_count) begin
                res.issue_command = 1'b1;
                res.cmd_stop      = 1'b1;
                res.cmd_enable    = 1'b1;
                wr_phase_d        = PH_STOP;
              end else begin
                wr_phase_d = PH_PREP;
              end
            end
          end
        end
        PH_STOP: begin
          if (!item_i.stop_pending) begin
            res.outcome = OUT_OK;
            wr_phase_d  = PH_IDLE;
          end
        end
        default: begin
          wr_count_d        = '0;
          res.issue_command = 1'b1;
          res.cmd_start     = 1'b1;
          res.cmd_enable    = 1'b1;
          wr_phase_d        = PH_START;
        end
      endcase
      res.bytes_done = wr_count_d;
    end else begin
      unique case (rd_phase_q)
        PH_START: begin
          if (!item_i.engine_busy) begin
            if (item_i.bus_status != StStart) begin
              res.issue_command = 1'b1;
              res.cmd_stop      = 1'b1;
              res.outcome       = OUT_FAIL;
              rd_phase_d        = PH_IDLE;
            end else begin
              res.load_data     = 1'b1;
              res.data_out      = {item_i.device_addr, 1'b1};
              res.issue_command = 1'b1;
              res.cmd_enable    = 1'b1;
              rd_phase_d        = PH_ADDR;
            end
          end
        end
        PH_ADDR, PH_GET: begin
          if (rd_phase_q == PH_ADDR && !item_i.engine_busy &&
              item_i.bus_status != StMrSla) begin
            res.outcome = OUT_FAIL;
            rd_phase_d  = PH_IDLE;
          end else if (rd_phase_q == PH_GET || !item_i.engine_busy) begin
            res.issue_command = 1'b1;
            res.cmd_ack       = !rd_last;
            res.cmd_enable    = 1'b1;
            rd_phase_d        = PH_GOT;
          end
        end
        PH_GOT: begin
          if (!item_i.engine_busy) begin
            if (item_i.bus_status != (rd_last ? StMrNack : StMrData)) begin
              res.outcome = OUT_FAIL;
              rd_phase_d  = PH_IDLE;
            end else begin
              res.got_byte   = 1'b1;
              res.got_data   = item_i.read_byte;
              res.byte_index = rd_count_q;
              rd_count_d     = rd_count_q + 8'd1;
              if (rd_count_d == item_i.byte_count) begin
                res.issue_command = 1'b1;
                res.cmd_stop      = 1'b1;
                res.cmd_enable    = 1'b1;
                rd_phase_d        = PH_STOP;
              end else begin
                rd_phase_d = PH_GET;
              end
            end
          end
        end
        PH_STOP: begin
          if (!item_i.stop_pending) begin
            res.outcome = OUT_OK;
            rd_phase_d  = PH_IDLE;
          end
        end
        default: begin
          rd_count_d        = '0;
          res.issue_command = 1'b1;
          res.cmd_start     = 1'b1;
          res.cmd_enable    = 1'b1;
          rd_phase_d        = PH_START;
        end
      endcase
      res.bytes_done = rd_count_d;
    end
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_phase_q <= PH_IDLE;
      rd_phase_q <= PH_IDLE;
      wr_count_q <= '0;
      rd_count_q <= '0;
    end else if (en_i) begin
      wr_phase_q <= wr_phase_d;
      rd_phase_q <= rd_phase_d;
      wr_count_q <= wr_count_d;
      rd_count_q <= rd_count_d;
    end
  end

`ifndef SYNTHESIS
  a_wr_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && !item_i.req_type && res.outcome != OUT_BUSY |=> wr_phase_q == PH_IDLE)
    else $error("write side not idle after finishing");
  a_rd_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && item_i.req_type && res.outcome != OUT_BUSY |=> rd_phase_q == PH_IDLE)
    else $error("read side not idle after finishing");
  a_read_untouched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && !item_i.req_type |=> rd_phase_q == $past(rd_phase_q) &&
    rd_count_q == $past(rd_count_q))
    else $error("write poll changed read state");
  a_cmd_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res.issue_command |-> !res.cmd_start && !res.cmd_stop && !res.cmd_ack &&
    !res.cmd_enable)
    else $error("command flags without command");
`endif

endmodule

[design/i2c_master_transaction_sequencer_core.sv]
// I2C master transaction sequencer core.
// Each transfer on the slave-side stream is one poll of the write side
// (tuser 0) or the read side (tuser 1), carrying the byte engine's busy and
// stop-pending flags, its status code and its received byte. Each poll yields
// exactly one result transfer on the master-side stream: the outcome (in
// progress, ok, failed), at most one engine command, an optional byte for the
// engine transmit register, an optional received byte, and byte counters.
// A poll is registered on entry, evaluated combinationally by the sequencer
// logic, and its result is registered on the way out. One poll per cycle is
// sustained while the master side does not stall. When the master side
// stalls, the result register holds and the input register fills; the slave
// side then deasserts tready until the result is taken. Polls are evaluated
// strictly in order. Reset clears both phases to idle, both byte counters to
// zero and empties both registers.
module i2c_master_transaction_sequencer_core
  import i2cseq_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // device_addr[6:0], byte_count[14:7], write_byte[22:15], engine_busy[23],
  // stop_pending[24], bus_status[32:25], read_byte[40:33], zero[47:41]
  input  logic [InDataW-1:0]  s_axis_tdata,
  // req_type[0]
  input  logic                s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // outcome[1:0], issue_command[2], cmd_start[3], cmd_stop[4], cmd_ack[5],
  // cmd_enable[6], load_data[7], data_out[15:8], got_byte[16], got_data[24:17],
  // byte_index[32:25], bytes_done[40:33], zero[47:41]
  output logic [OutDataW-1:0] m_axis_tdata
);

  logic    in_valid_q;
  poll_t   in_q;
  logic    out_valid_q;
  result_t out_q;
  result_t res;
  logic    advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q.req_type     <= s_axis_tuser;
      in_q.device_addr  <= s_axis_tdata[6:0];
      in_q.byte_count   <= s_axis_tdata[14:7];
      in_q.write_byte   <= s_axis_tdata[22:15];
      in_q.engine_busy  <= s_axis_tdata[23];
      in_q.stop_pending <= s_axis_tdata[24];
      in_q.bus_status   <= s_axis_tdata[32:25];
      in_q.read_byte    <= s_axis_tdata[40:33];
    end
    if (advance) begin
      out_q <= res;
    end
  end

  i2cseq_poll u_poll (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .item_i (in_q),
    .res_o  (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_q.bytes_done, out_q.byte_index, out_q.got_data,
                          out_q.got_byte, out_q.data_out, out_q.load_data,
                          out_q.cmd_enable, out_q.cmd_ack, out_q.cmd_stop,
                          out_q.cmd_start, out_q.issue_command, out_q.outcome};

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_in_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while both registers are full");
  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> m_axis_tvalid)
    else $error("evaluated poll lost its result");
`endif

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

import i2cseq_pkg::*;

class txn_tracker;
  phase_e      wr_phase;
  phase_e      rd_phase;
  logic [7:0]  wr_done;
  logic [7:0]  rd_done;
  result_t     pending_results[$];
  int unsigned checked;
  int unsigned mismatches;
  int unsigned write_polls;
  int unsigned read_polls;
  int unsigned txn_ok;
  int unsigned txn_failed;
  int unsigned bytes_received;

  function new();
    wr_phase = PH_IDLE;
    rd_phase = PH_IDLE;
    wr_done  = 8'd0;
    rd_done  = 8'd0;
  endfunction

  function result_t add_command(result_t r, bit start, bit stop, bit ack, bit enable);
    r.issue_command = 1'b1;
    r.cmd_start     = start;
    r.cmd_stop      = stop;
    r.cmd_ack       = ack;
    r.cmd_enable    = enable;
    return r;
  endfunction

  function result_t sequence_write(poll_t p);
    result_t r;
    r = '0;
    case (wr_phase)
      PH_START: if (!p.engine_busy) begin
        if (p.bus_status != StStart) begin
          r = add_command(r, 1'b0, 1'b1, 1'b0, 1'b0);
          r.outcome = OUT_FAIL;
          wr_phase = PH_IDLE;
        end else begin
          r.load_data = 1'b1;
          r.data_out  = {p.device_addr, 1'b0};
          r = add_command(r, 1'b0, 1'b0, 1'b0, 1'b1);
          wr_phase = PH_ADDR;
        end
      end
      PH_ADDR, PH_PREP: if (wr_phase == PH_PREP || !p.engine_busy) begin
        if (wr_phase == PH_ADDR && p.bus_status != StMtSla) begin
          r.outcome = OUT_FAIL;
          wr_phase = PH_IDLE;
        end else begin
          r.load_data  = 1'b1;
          r.data_out   = p.write_byte;
          r.byte_index = wr_done;
          r = add_command(r, 1'b0, 1'b0, 1'b0, 1'b1);
          wr_phase = PH_SENT;
        end
      end
      PH_SENT: if (!p.engine_busy) begin
        if (p.bus_status != StMtData) begin
          r.outcome = OUT_FAIL;
          wr_phase = PH_IDLE;
        end else begin
          wr_done = wr_done + 8'd1;
          if (wr_done == p.byte_count) begin
            r = add_command(r, 1'b0, 1'b1, 1'b0, 1'b1);
            wr_phase = PH_STOP;
          end else begin
            wr_phase = PH_PREP;
          end
        end
      end
      PH_STOP: if (!p.stop_pending) begin
        r.outcome = OUT_OK;
        wr_phase = PH_IDLE;
      end
      default: begin
        wr_done = 8'd0;
        r = add_command(r, 1'b1, 1'b0, 1'b0, 1'b1);
        wr_phase = PH_START;
      end
    endcase
    r.bytes_done = wr_done;
    return r;
  endfunction

  function result_t sequence_read(poll_t p);
    result_t    r;
    logic [7:0] left_cnt;
    logic       last;
    r = '0;
    left_cnt = p.byte_count - rd_done;
    last = (left_cnt == 8'd1);
    case (rd_phase)
      PH_START: if (!p.engine_busy) begin
        if (p.bus_status != StStart) begin
          r = add_command(r, 1'b0, 1'b1, 1'b0, 1'b0);
          r.outcome = OUT_FAIL;
          rd_phase = PH_IDLE;
        end else begin
          r.load_data = 1'b1;
          r.data_out  = {p.device_addr, 1'b1};
          r = add_command(r, 1'b0, 1'b0, 1'b0, 1'b1);
          rd_phase = PH_ADDR;
        end
      end
      PH_ADDR, PH_GET: if (rd_phase == PH_GET || !p.engine_busy) begin
        if (rd_phase == PH_ADDR && p.bus_status != StMrSla) begin
          r.outcome = OUT_FAIL;
          rd_phase = PH_IDLE;
        end else begin
          r = add_command(r, 1'b0, 1'b0, !last, 1'b1);
          rd_phase = PH_GOT;
        end
      end
      PH_GOT: if (!p.engine_busy) begin
        if (p.bus_status != (last ? StMrNack : StMrData)) begin
          r.outcome = OUT_FAIL;
          rd_phase = PH_IDLE;
        end else begin
          r.got_byte   = 1'b1;
          r.got_data   = p.read_byte;
          r.byte_index = rd_done;
          rd_done = rd_done + 8'd1;
          if (rd_done == p.byte_count) begin
            r = add_command(r, 1'b0, 1'b1, 1'b0, 1'b1);
            rd_phase = PH_STOP;
          end else begin
            rd_phase = PH_GET;
          end
        end
      end
      PH_STOP: if (!p.stop_pending) begin
        r.outcome = OUT_OK;
        rd_phase = PH_IDLE;
      end
      default: begin
        rd_done = 8'd0;
        r = add_command(r, 1'b1, 1'b0, 1'b0, 1'b1);
        rd_phase = PH_START;
      end
    endcase
    r.bytes_done = rd_done;
    return r;
  endfunction

  function void note_poll(poll_t p);
    result_t r;
    if (p.req_type) begin
      r = sequence_read(p);
      read_polls++;
    end else begin
      r = sequence_write(p);
      write_polls++;
    end
    if (r.outcome == OUT_OK) txn_ok++;
    if (r.outcome == OUT_FAIL) txn_failed++;
    if (r.got_byte) bytes_received++;
    pending_results.push_back(r);
  endfunction

  function int pending();
    return pending_results.size();
  endfunction

  function void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Result %0d: %s expected 0x%0h, got 0x%0h", checked, name, want, got);
    end
  endfunction

  function void check_result(logic [OutDataW-1:0] d);
    result_t want;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("Unexpected result transfer 0x%0h", d);
      return;
    end
    want = pending_results.pop_front();
    compare_field("outcome", want.outcome, d[1:0]);
    compare_field("issue_command", want.issue_command, d[2]);
    compare_field("cmd_start", want.cmd_start, d[3]);
    compare_field("cmd_stop", want.cmd_stop, d[4]);
    compare_field("cmd_ack", want.cmd_ack, d[5]);
    compare_field("cmd_enable", want.cmd_enable, d[6]);
    compare_field("load_data", want.load_data, d[7]);
    compare_field("data_out", want.data_out, d[15:8]);
    compare_field("got_byte", want.got_byte, d[16]);
    compare_field("got_data", want.got_data, d[24:17]);
    compare_field("byte_index", want.byte_index, d[32:25]);
    compare_field("bytes_done", want.bytes_done, d[40:33]);
    checked++;
  endfunction
endclass

module testbench;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandomPolls = 1200;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tuser = 1'b0;
  logic                m_axis_tready = 1'b0;
  wire                 s_axis_tready;
  wire                 m_axis_tvalid;
  wire [OutDataW-1:0]  m_axis_tdata;

  txn_tracker  sb = new();
  int unsigned cycle_count = 0;
  int          hold_left = 0;
  int          calm_left = 0;
  bit          long_hold_done = 1'b0;
  logic [6:0]  txn_addr[2];
  logic [7:0]  txn_count[2];

  i2c_master_transaction_sequencer_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, sb.pending());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 80) return $urandom_range(1, 3);
    if (sel < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [7:0] pick_count();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return 8'($urandom_range(1, 4));
    if (sel < 95) return 8'($urandom_range(5, 16));
    if (sel < 99) return 8'($urandom_range(17, 255));
    return 8'd0;
  endfunction

  // The receiver stalls at random and holds off once for a long stretch so
  // that the block fills up and pushes back on its input.
  always @(posedge clk_i) begin
    if (!long_hold_done && sb.checked >= 300) begin
      long_hold_done = 1'b1;
      hold_left = 150;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (calm_left > 0) begin
      calm_left--;
      m_axis_tready <= 1'b1;
    end else begin
      case ($urandom_range(0, 9))
        0:       calm_left = $urandom_range(20, 80);
        1, 2:    hold_left = pick_gap();
        default: ;
      endcase
      m_axis_tready <= (hold_left == 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  function automatic poll_t mk(bit rt, logic [6:0] addr, logic [7:0] cnt, logic [7:0] wb,
                               bit busy, bit stp, logic [7:0] st, logic [7:0] rb);
    poll_t p;
    p.req_type     = rt;
    p.device_addr  = addr;
    p.byte_count   = cnt;
    p.write_byte   = wb;
    p.engine_busy  = busy;
    p.stop_pending = stp;
    p.bus_status   = st;
    p.read_byte    = rb;
    return p;
  endfunction

  // Mostly the status the engine gives on success in the current phase, so
  // that transactions run to completion; now and then a corrupted poll.
  function automatic poll_t make_poll(bit side);
    poll_t      p;
    phase_e     ph;
    logic [7:0] done_cnt;
    logic [7:0] left_cnt;
    ph = side ? sb.rd_phase : sb.wr_phase;
    done_cnt = side ? sb.rd_done : sb.wr_done;
    if (ph == PH_IDLE) begin
      txn_addr[side]  = 7'($urandom_range(0, 127));
      txn_count[side] = pick_count();
    end
    p.req_type     = side;
    p.device_addr  = txn_addr[side];
    p.byte_count   = txn_count[side];
    p.write_byte   = 8'($urandom_range(0, 255));
    p.read_byte    = 8'($urandom_range(0, 255));
    p.engine_busy  = ($urandom_range(0, 4) == 0);
    p.stop_pending = ($urandom_range(0, 2) == 0);
    left_cnt = p.byte_count - done_cnt;
    case (ph)
      PH_START: p.bus_status = StStart;
      PH_ADDR:  p.bus_status = side ? StMrSla : StMtSla;
      PH_SENT:  p.bus_status = StMtData;
      PH_GOT:   p.bus_status = (left_cnt == 8'd1) ? StMrNack : StMrData;
      default:  p.bus_status = 8'($urandom_range(0, 255));
    endcase
    if ($urandom_range(0, 29) == 0) p.bus_status = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 9) == 0) begin
      p.device_addr = 7'($urandom_range(0, 127));
      p.byte_count  = 8'($urandom_range(0, 255));
      p.engine_busy = 1'($urandom_range(0, 1));
      p.bus_status  = 8'($urandom_range(0, 255));
    end
    return p;
  endfunction

  task automatic send_poll(input poll_t p, input int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= p.req_type;
    s_axis_tdata  <= {7'd0, p.read_byte, p.bus_status, p.stop_pending, p.engine_busy,
                      p.write_byte, p.byte_count, p.device_addr};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_poll(p);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() > 0);
  endtask

  initial begin
    poll_t directed[$];
    int    gap;
    int    burst;
    int    n;
    bit    side;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Write of one byte to the highest address, with a busy poll and a held stop.
    directed.push_back(mk(0, 7'd127, 8'd1, 8'hFF, 0, 0, 8'h00, 8'h00));
    directed.push_back(mk(0, 7'd127, 8'd1, 8'hFF, 1, 0, StStart, 8'h00));
    directed.push_back(mk(0, 7'd127, 8'd1, 8'hFF, 0, 0, StStart, 8'h00));
    directed.push_back(mk(0, 7'd127, 8'd1, 8'hFF, 0, 0, StMtSla, 8'h00));
    directed.push_back(mk(0, 7'd127, 8'd1, 8'hFF, 0, 0, StMtData, 8'h00));
    directed.push_back(mk(0, 7'd127, 8'd1, 8'hFF, 0, 1, 8'h00, 8'h00));
    directed.push_back(mk(0, 7'd127, 8'd1, 8'hFF, 0, 0, 8'h00, 8'h00));
    // Read of two bytes from address zero: ack on the first, nack on the last.
    directed.push_back(mk(1, 7'd0, 8'd2, 8'h00, 0, 0, 8'h00, 8'h00));
    directed.push_back(mk(1, 7'd0, 8'd2, 8'h00, 0, 0, StStart, 8'h00));
    directed.push_back(mk(1, 7'd0, 8'd2, 8'h00, 0, 0, StMrSla, 8'h00));
    directed.push_back(mk(1, 7'd0, 8'd2, 8'h00, 0, 0, StMrData, 8'hA5));
    directed.push_back(mk(1, 7'd0, 8'd2, 8'h00, 0, 0, 8'h00, 8'h00));
    directed.push_back(mk(1, 7'd0, 8'd2, 8'h00, 0, 0, StMrNack, 8'h5A));
    directed.push_back(mk(1, 7'd0, 8'd2, 8'h00, 0, 0, 8'h00, 8'h00));
    // Start failure, write address nack, and a read ending with the wrong status.
    directed.push_back(mk(0, 7'h55, 8'd255, 8'h00, 0, 0, 8'h00, 8'h00));
    directed.push_back(mk(0, 7'h55, 8'd255, 8'h00, 0, 0, 8'hFF, 8'hFF));
    directed.push_back(mk(0, 7'h2A, 8'd3, 8'h00, 0, 0, 8'h00, 8'h00));
    directed.push_back(mk(0, 7'h2A, 8'd3, 8'h00, 0, 0, StStart, 8'h00));
    directed.push_back(mk(0, 7'h2A, 8'd3, 8'h00, 0, 0, 8'h20, 8'h00));
    directed.push_back(mk(1, 7'h33, 8'd1, 8'h00, 0, 0, 8'h00, 8'h00));
    directed.push_back(mk(1, 7'h33, 8'd1, 8'h00, 0, 0, StStart, 8'h00));
    directed.push_back(mk(1, 7'h33, 8'd1, 8'h00, 0, 0, StMrSla, 8'h00));
    directed.push_back(mk(1, 7'h33, 8'd1, 8'h00, 0, 0, StMrData, 8'hFF));
    foreach (directed[i]) send_poll(directed[i], $urandom_range(0, 1) ? 0 : pick_gap());

    side  = 1'b0;
    burst = 0;
    for (n = 0; n < RandomPolls; n++) begin
      if (n == 400 || n == 800) drain_results();
      if (burst > 0) burst--;
      else if ($urandom_range(0, 19) == 0) burst = $urandom_range(20, 60);
      if ((side ? sb.rd_phase : sb.wr_phase) == PH_IDLE) begin
        if ($urandom_range(0, 1)) side = ~side;
      end else if ($urandom_range(0, 19) == 0) begin
        side = ~side;
      end
      gap = (burst > 0 || $urandom_range(0, 1)) ? 0 : pick_gap();
      send_poll(make_poll(side), gap);
    end

    drain_results();
    repeat (20) @(posedge clk_i);
    $display("Polls: %0d write side, %0d read side; %0d results checked, %0d mismatches.",
             sb.write_polls, sb.read_polls, sb.checked, sb.mismatches);
    $display("Transactions: %0d completed, %0d failed; %0d bytes received.",
             sb.txn_ok, sb.txn_failed, sb.bytes_received);
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
